### sv/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared constants, widths and types for the quaternion vector rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

	// Quaternion components are signed Q2.30 at the default fraction width.
	localparam int QUAT_BITS = 32;

	// Defaults for the top-level parameters.
	localparam int VEC_BITS_DEF       = 32;
	localparam int QUAT_FRAC_BITS_DEF = 30;

	// Intermediate quaternion components clip to this signed width.
	localparam int P_CLAMP_BITS = 64;

	// Control that travels alongside the data between the two halves.
	typedef struct packed {
		logic valid;
		logic sat;
	} qvr_ctl_t;

	// Width of an exact sum of three quaternion-by-vector products.
	function automatic int sum1_width(int vb);
		return QUAT_BITS + vb + 2;
	endfunction

	// Width of one component of conj(q)*v after the shift and the clip.
	function automatic int p_width(int vb, int fb);
		int full;
		full = sum1_width(vb) - fb;
		return (full > P_CLAMP_BITS) ? P_CLAMP_BITS : full;
	endfunction

	// Width that holds the exact sum of four p-by-q products and still leaves
	// at least one guard bit above the output after the shift.
	function automatic int sum2_width(int vb, int fb);
		int exact;
		int least;
		exact = p_width(vb, fb) + QUAT_BITS + 2;
		least = fb + vb + 1;
		return (exact > least) ? exact : least;
	endfunction

endpackage

`default_nettype wire

### sv/quaternion_vector_rotate.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// The result strobes on done once it has passed the registers of stages s1 to s5.
// Throughput: one rotation per cycle; busy never rises, since each Hamilton
// product has its own multiplier bank and the five-stage pipeline never stalls.
// Reset clears the valid bits and the inner clip flags; no result strobes until a new transaction.
// The receiver cannot stall: each result stands on the ports for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_vector_rotate #(
	parameter int VEC_BITS       = qvr_pkg::VEC_BITS_DEF,
	parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic signed [qvr_pkg::QUAT_BITS-1:0] quat_w,
	input  wire logic signed [qvr_pkg::QUAT_BITS-1:0] quat_x,
	input  wire logic signed [qvr_pkg::QUAT_BITS-1:0] quat_y,
	input  wire logic signed [qvr_pkg::QUAT_BITS-1:0] quat_z,
	input  wire logic signed [VEC_BITS-1:0]           vec_x,
	input  wire logic signed [VEC_BITS-1:0]           vec_y,
	input  wire logic signed [VEC_BITS-1:0]           vec_z,
	output logic                                      done,
	output logic signed [VEC_BITS-1:0]                rot_x,
	output logic signed [VEC_BITS-1:0]                rot_y,
	output logic signed [VEC_BITS-1:0]                rot_z,
	output logic                                      saturated
);

	localparam int QB  = qvr_pkg::QUAT_BITS;
	localparam int P_W = qvr_pkg::p_width(VEC_BITS, QUAT_FRAC_BITS);

	logic                          valid_s1;
	logic signed [QB-1:0]          q_s1 [4];
	logic signed [VEC_BITS-1:0]    v_s1 [3];

	qvr_pkg::qvr_ctl_t             ctl_s3;
	logic signed [QB-1:0]          q_s3 [4];
	logic signed [P_W-1:0]         p_s3 [4];

	logic signed [VEC_BITS-1:0]    rot_s5 [3];

	// The pipeline takes a transaction every cycle.
	assign busy = 1'b0;

	// Capture the transaction at the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		q_s1[0] <= quat_w;
		q_s1[1] <= quat_x;
		q_s1[2] <= quat_y;
		q_s1[3] <= quat_z;
		v_s1[0] <= vec_x;
		v_s1[1] <= vec_y;
		v_s1[2] <= vec_z;
	end

	// First Hamilton product: conj(q) * (0, v).
	qvr_conj #(
		.VEC_BITS       (VEC_BITS),
		.QUAT_FRAC_BITS (QUAT_FRAC_BITS)
	) u_conj (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.q_in     (q_s1),
		.v_in     (v_s1),
		.ctl_s3   (ctl_s3),
		.q_s3     (q_s3),
		.p_s3     (p_s3)
	);

	// Second Hamilton product: vector part of p * q, saturated.
	qvr_sandwich #(
		.VEC_BITS       (VEC_BITS),
		.QUAT_FRAC_BITS (QUAT_FRAC_BITS)
	) u_sandwich (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s3   (ctl_s3),
		.q_s3     (q_s3),
		.p_s3     (p_s3),
		.valid_s5 (done),
		.sat_s5   (saturated),
		.rot_s5   (rot_s5)
	);

	assign rot_x = rot_s5[0];
	assign rot_y = rot_s5[1];
	assign rot_z = rot_s5[2];

endmodule

`default_nettype wire

### sv/qvr_conj.sv
// ----------------------------------------------------------------------------
// qvr_conj
// Two pipeline stages that form p = conj(q) * (0, v): a bank of twelve
// products, then signed sums, arithmetic shift and a clip to at most 64 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_conj #(
	parameter int VEC_BITS       = qvr_pkg::VEC_BITS_DEF,
	parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF,
	localparam int P_W           = qvr_pkg::p_width(VEC_BITS, QUAT_FRAC_BITS)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire logic signed [qvr_pkg::QUAT_BITS-1:0] q_in [4],
	input  wire logic signed [VEC_BITS-1:0]        v_in [3],
	output qvr_pkg::qvr_ctl_t                      ctl_s3,
	output logic signed [qvr_pkg::QUAT_BITS-1:0]   q_s3 [4],
	output logic signed [P_W-1:0]                  p_s3 [4]
);

	localparam int QB   = qvr_pkg::QUAT_BITS;
	localparam int M_W  = QB + VEC_BITS;
	localparam int S_W  = qvr_pkg::sum1_width(VEC_BITS);

	logic                   valid_s2;
	logic signed [QB-1:0]   q_s2 [4];
	logic signed [M_W-1:0]  prod_s2 [12];

	logic signed [S_W-1:0]  sum_c [4];
	logic signed [S_W-1:0]  sh_c [4];
	logic signed [P_W-1:0]  clip_c [4];
	logic [3:0]             ovf_c;

	// Advance the valid bit through both stages, with the clip flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2      <= 1'b0;
			ctl_s3.valid  <= 1'b0;
			ctl_s3.sat    <= 1'b0;
		end else begin
			valid_s2      <= in_valid;
			ctl_s3.valid  <= valid_s2;
			ctl_s3.sat    <= |ovf_c;
		end
	end

	// Form all quaternion-by-vector products; q = (w, x, y, z), v = (x, y, z).
	always_ff @(posedge clk) begin
		q_s2        <= q_in;
		prod_s2[0]  <= q_in[1] * v_in[0];
		prod_s2[1]  <= q_in[2] * v_in[1];
		prod_s2[2]  <= q_in[3] * v_in[2];
		prod_s2[3]  <= q_in[0] * v_in[0];
		prod_s2[4]  <= q_in[2] * v_in[2];
		prod_s2[5]  <= q_in[3] * v_in[1];
		prod_s2[6]  <= q_in[0] * v_in[1];
		prod_s2[7]  <= q_in[3] * v_in[0];
		prod_s2[8]  <= q_in[1] * v_in[2];
		prod_s2[9]  <= q_in[0] * v_in[2];
		prod_s2[10] <= q_in[1] * v_in[1];
		prod_s2[11] <= q_in[2] * v_in[0];
	end

	// Sum with the Hamilton signs, shift down and clip each component.
	always_comb begin
		sum_c[0] = S_W'(prod_s2[0]) + S_W'(prod_s2[1])  + S_W'(prod_s2[2]);
		sum_c[1] = S_W'(prod_s2[3]) - S_W'(prod_s2[4])  + S_W'(prod_s2[5]);
		sum_c[2] = S_W'(prod_s2[6]) - S_W'(prod_s2[7])  + S_W'(prod_s2[8]);
		sum_c[3] = S_W'(prod_s2[9]) - S_W'(prod_s2[10]) + S_W'(prod_s2[11]);
		for (int i = 0; i < 4; i++) begin
			sh_c[i]  = sum_c[i] >>> QUAT_FRAC_BITS;
			ovf_c[i] = !((&sh_c[i][S_W-1:P_W-1]) || !(|sh_c[i][S_W-1:P_W-1]));
			if (ovf_c[i]) begin
				clip_c[i] = sh_c[i][S_W-1] ? {1'b1, {(P_W-1){1'b0}}}
				                           : {1'b0, {(P_W-1){1'b1}}};
			end else begin
				clip_c[i] = sh_c[i][P_W-1:0];
			end
		end
	end

	// Hold the clipped components and pass q along for the second product.
	always_ff @(posedge clk) begin
		q_s3        <= q_s2;
		p_s3        <= clip_c;
	end

endmodule

`default_nettype wire

### sv/qvr_sandwich.sv
// ----------------------------------------------------------------------------
// qvr_sandwich
// Two pipeline stages that form the vector part of p * q: a bank of twelve
// products, then the signed sums, the arithmetic shift and the output clip.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_sandwich #(
	parameter int VEC_BITS       = qvr_pkg::VEC_BITS_DEF,
	parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF,
	localparam int P_W           = qvr_pkg::p_width(VEC_BITS, QUAT_FRAC_BITS)
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire qvr_pkg::qvr_ctl_t                    ctl_s3,
	input  wire logic signed [qvr_pkg::QUAT_BITS-1:0] q_s3 [4],
	input  wire logic signed [P_W-1:0]                p_s3 [4],
	output logic                                      valid_s5,
	output logic                                      sat_s5,
	output logic signed [VEC_BITS-1:0]                rot_s5 [3]
);

	localparam int QB  = qvr_pkg::QUAT_BITS;
	localparam int M_W = P_W + QB;
	localparam int S_W = qvr_pkg::sum2_width(VEC_BITS, QUAT_FRAC_BITS);

	qvr_pkg::qvr_ctl_t           ctl_s4;
	logic signed [M_W-1:0]       prod_s4 [12];

	logic signed [S_W-1:0]       sum_c [3];
	logic signed [S_W-1:0]       sh_c [3];
	logic signed [VEC_BITS-1:0]  clip_c [3];
	logic [2:0]                  ovf_c;

	// Advance the valid bit through both stages, with the clip flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4.valid <= 1'b0;
			ctl_s4.sat   <= 1'b0;
			valid_s5     <= 1'b0;
		end else begin
			ctl_s4.valid <= ctl_s3.valid;
			ctl_s4.sat   <= ctl_s3.sat;
			valid_s5     <= ctl_s4.valid;
		end
	end

	// Form the products; each group of four feeds one output component,
	// the last of each group entering with a minus sign.
	always_ff @(posedge clk) begin
		prod_s4[0]  <= p_s3[0] * q_s3[1];
		prod_s4[1]  <= q_s3[0] * p_s3[1];
		prod_s4[2]  <= p_s3[2] * q_s3[3];
		prod_s4[3]  <= p_s3[3] * q_s3[2];
		prod_s4[4]  <= p_s3[0] * q_s3[2];
		prod_s4[5]  <= q_s3[0] * p_s3[2];
		prod_s4[6]  <= p_s3[3] * q_s3[1];
		prod_s4[7]  <= p_s3[1] * q_s3[3];
		prod_s4[8]  <= p_s3[0] * q_s3[3];
		prod_s4[9]  <= q_s3[0] * p_s3[3];
		prod_s4[10] <= p_s3[1] * q_s3[2];
		prod_s4[11] <= p_s3[2] * q_s3[1];
	end

	// Sum, shift down and saturate each output component.
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sum_c[j] = S_W'(prod_s4[4*j])     + S_W'(prod_s4[4*j + 1])
			         + S_W'(prod_s4[4*j + 2]) - S_W'(prod_s4[4*j + 3]);
			sh_c[j]  = sum_c[j] >>> QUAT_FRAC_BITS;
			ovf_c[j] = !((&sh_c[j][S_W-1:VEC_BITS-1]) || !(|sh_c[j][S_W-1:VEC_BITS-1]));
			if (ovf_c[j]) begin
				clip_c[j] = sh_c[j][S_W-1] ? {1'b1, {(VEC_BITS-1){1'b0}}}
				                           : {1'b0, {(VEC_BITS-1){1'b1}}};
			end else begin
				clip_c[j] = sh_c[j][VEC_BITS-1:0];
			end
		end
	end

	// Hold the result for its strobe cycle.
	always_ff @(posedge clk) begin
		rot_s5 <= clip_c;
		sat_s5 <= ctl_s4.sat | (|ovf_c);
	end

endmodule

`default_nettype wire
